// ----- rtl/core/gimbal_frame_mecanum_wheel_mixer_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the gimbal frame mecanum mixer
// Expect clk and rst_n in the scope of every use.
// ---------------------------------------------------------------------------
`ifndef GIMBAL_FRAME_MECANUM_WHEEL_MIXER_UNIT_MACROS_SVH
`define GIMBAL_FRAME_MECANUM_WHEEL_MIXER_UNIT_MACROS_SVH

// same-cycle implication
`define GFMW_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFMW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/gfmw_pkg.sv -----
// ---------------------------------------------------------------------------
// gfmw_pkg
// Types, constants and the sine table builder shared by the mixer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package gfmw_pkg;

  localparam int ENC_COUNTS = 8192;
  localparam int ENC_HALF   = ENC_COUNTS / 2;
  localparam int LUT_LAST   = ENC_COUNTS / 4;
  localparam int LUT_DEPTH  = LUT_LAST + 1;
  localparam int LUT_AW     = $clog2(LUT_DEPTH);
  localparam int SIN_W      = 15;
  localparam real SIN_SCALE = 16384.0;
  localparam real PI_R      = 3.14159265358979323846;

  localparam logic signed [15:0] MIX_K = 16'sd23170;
  localparam logic signed [9:0]  VW_K  = 10'sd320;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic {
    REG_YAW_ZERO   = 1'b0,
    REG_WHEEL_GAIN = 1'b1
  } cfg_reg_t;

  typedef logic [SIN_W-1:0] sin_lut_t [0:LUT_DEPTH-1];

  typedef struct packed {
    logic signed [13:0] rel_angle;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vw;
  } item_t;

  // quarter-wave sine, round half up to Q1.14, built at elaboration
  function automatic sin_lut_t build_sin_lut();
    sin_lut_t lut;
    real ang;
    real v;
    for (int j = 0; j < LUT_DEPTH; j++) begin
      ang = 2.0 * PI_R * j / ENC_COUNTS;
      v = $floor(SIN_SCALE * $sin(ang) + 0.5);
      lut[j] = SIN_W'($rtoi(v));
    end
    return lut;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gimbal_frame_mecanum_wheel_mixer_unit.sv -----
// Pipeline: 2 front stages incl. the registered sine ROM read, 1 queue, 5+1 back stages.
// Throughput: one beat per cycle while neither out_ready nor a full queue stalls it;
// the four lanes each have one multiplier, in back stages 3 and 5.
// Reset: synchronous active-low rst_n empties both pipelines and the queue and
// sets yaw_zero to 0 and wheel_gain to 256 (1/4096 in unsigned Q0.20).
// ---------------------------------------------------------------------------
// gimbal_frame_mecanum_wheel_mixer_unit
// Gimbal frame velocity rotation and mecanum wheel mixing with APB registers.
// ---------------------------------------------------------------------------
`default_nettype none

module gimbal_frame_mecanum_wheel_mixer_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [12:0]        in_yaw_angle,
  input  wire logic signed [15:0] in_target_vx,
  input  wire logic signed [15:0] in_target_vy,
  input  wire logic signed [15:0] in_target_vw,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [13:0]      out_relative_angle,
  output logic signed [15:0]      out_wheel0_speed,
  output logic signed [15:0]      out_wheel1_speed,
  output logic signed [15:0]      out_wheel2_speed,
  output logic signed [15:0]      out_wheel3_speed
);
  import gfmw_pkg::*;

  logic [12:0]  yaw_zero_r;
  logic [15:0]  wheel_gain_r;
  logic         cfg_wr;
  cfg_reg_t     reg_sel;

  logic         f_valid, f_ready;
  item_t        f_item;
  logic         b_valid, b_ready;
  item_t        b_item;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_zero_r   <= '0;
      wheel_gain_r <= 16'd256;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_YAW_ZERO:   yaw_zero_r   <= pwdata[12:0];
        REG_WHEEL_GAIN: wheel_gain_r <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_YAW_ZERO:   prdata = {19'd0, yaw_zero_r};
      REG_WHEEL_GAIN: prdata = {16'd0, wheel_gain_r};
      default:        prdata = '0;
    endcase
  end

  gfmw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_yaw_angle (in_yaw_angle),
    .in_target_vx (in_target_vx),
    .in_target_vy (in_target_vy),
    .in_target_vw (in_target_vw),
    .yaw_zero     (yaw_zero_r),
    .item_valid   (f_valid),
    .item         (f_item),
    .item_ready   (f_ready)
  );

  gfmw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_item  (b_item)
  );

  gfmw_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (b_valid),
    .item_ready         (b_ready),
    .item               (b_item),
    .wheel_gain         (wheel_gain_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_relative_angle (out_relative_angle),
    .out_wheel0_speed   (out_wheel0_speed),
    .out_wheel1_speed   (out_wheel1_speed),
    .out_wheel2_speed   (out_wheel2_speed),
    .out_wheel3_speed   (out_wheel3_speed)
  );

endmodule

`default_nettype wire

// ----- rtl/core/gfmw_front.sv -----
// ---------------------------------------------------------------------------
// gfmw_front
// Wraps the yaw difference and looks up sine and cosine from the ROM.
// ---------------------------------------------------------------------------
`default_nettype none

module gfmw_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [12:0]        in_yaw_angle,
  input  wire logic signed [15:0] in_target_vx,
  input  wire logic signed [15:0] in_target_vy,
  input  wire logic signed [15:0] in_target_vw,
  input  wire logic [12:0]        yaw_zero,
  output logic                    item_valid,
  output gfmw_pkg::item_t         item,
  input  wire logic               item_ready
);
  import gfmw_pkg::*;

  localparam sin_lut_t SIN_LUT = build_sin_lut();
  localparam logic signed [14:0] HALF_S = 15'(ENC_HALF);
  localparam logic signed [14:0] ENC_S  = 15'(ENC_COUNTS);

  logic                    en;
  logic                    v1_r, v2_r;
  logic signed [14:0]      diff;
  logic signed [14:0]      wrapped;
  logic signed [13:0]      d1_r, d2_r;
  logic signed [15:0]      vx1_r, vy1_r, vw1_r;
  logic signed [15:0]      vx2_r, vy2_r, vw2_r;
  logic [12:0]             abs_v;
  logic [LUT_AW-1:0]       sin_idx, cos_idx;
  logic                    refl, neg_r, refl_r;
  logic [SIN_W-1:0]        sin_mag_r, cos_mag_r;

  assign en       = !v2_r || item_ready;
  assign in_ready = en;

  always_comb begin
    diff = $signed({2'b00, in_yaw_angle}) - $signed({2'b00, yaw_zero});
    if (diff > HALF_S) begin
      wrapped = diff - ENC_S;
    end else if (diff < -HALF_S) begin
      wrapped = diff + ENC_S;
    end else begin
      wrapped = diff;
    end
  end

  // fold |d| into the first quadrant
  always_comb begin
    abs_v   = d1_r[13] ? 13'(-d1_r) : 13'(d1_r);
    refl    = abs_v > 13'(LUT_LAST);
    sin_idx = refl ? LUT_AW'(13'(ENC_HALF) - abs_v) : LUT_AW'(abs_v);
    cos_idx = LUT_AW'(LUT_LAST) - sin_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r      <= 14'(wrapped);
      vx1_r     <= in_target_vx;
      vy1_r     <= in_target_vy;
      vw1_r     <= in_target_vw;
      sin_mag_r <= SIN_LUT[sin_idx];
      cos_mag_r <= SIN_LUT[cos_idx];
      neg_r     <= d1_r[13];
      refl_r    <= refl;
      d2_r      <= d1_r;
      vx2_r     <= vx1_r;
      vy2_r     <= vy1_r;
      vw2_r     <= vw1_r;
    end
  end

  always_comb begin
    item.rel_angle = d2_r;
    item.sin_v     = neg_r  ? -$signed({1'b0, sin_mag_r}) : $signed({1'b0, sin_mag_r});
    item.cos_v     = refl_r ? -$signed({1'b0, cos_mag_r}) : $signed({1'b0, cos_mag_r});
    item.vx        = vx2_r;
    item.vy        = vy2_r;
    item.vw        = vw2_r;
  end

  assign item_valid = v2_r;

endmodule

`default_nettype wire

// ----- rtl/core/gfmw_queue.sv -----
// ---------------------------------------------------------------------------
// gfmw_queue
// Short queue between the angle front end and the mixing back end.
// ---------------------------------------------------------------------------
`default_nettype none

`include "gimbal_frame_mecanum_wheel_mixer_unit_macros.svh"

module gfmw_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire gfmw_pkg::item_t  wr_item,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output gfmw_pkg::item_t       rd_item
);
  import gfmw_pkg::*;

  item_t           mem_r [QDEPTH];
  logic [QAW-1:0]  wptr_r, rptr_r;
  logic [QCW-1:0]  cnt_r;
  logic            push, pop;

  assign wr_ready = cnt_r != QCW'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

  `GFMW_ASSERT_IMPLY(a_q_cnt_bound, 1'b1, cnt_r <= QCW'(QDEPTH), "queue count above depth")
  `GFMW_ASSERT_NEXT(a_q_push_grows, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "push lost")
  `GFMW_ASSERT_NEXT(a_q_pop_shrinks, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "pop lost")

endmodule

`default_nettype wire

// ----- rtl/core/gfmw_back.sv -----
// ---------------------------------------------------------------------------
// gfmw_back
// Rotates the velocity into the chassis frame and mixes four wheel speeds.
// ---------------------------------------------------------------------------
`default_nettype none

module gfmw_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire gfmw_pkg::item_t  item,
  input  wire logic [15:0]      wheel_gain,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic signed [13:0]    out_relative_angle,
  output logic signed [15:0]    out_wheel0_speed,
  output logic signed [15:0]    out_wheel1_speed,
  output logic signed [15:0]    out_wheel2_speed,
  output logic signed [15:0]    out_wheel3_speed
);
  import gfmw_pkg::*;

  localparam int NST = 6;

  logic                en;
  logic [NST-1:0]      vld_r;
  logic signed [13:0]  ang_r [NST];

  // stage 1: rotation products
  logic signed [31:0]  pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [15:0]  vw1_r;
  // stage 2: wheel sums
  logic signed [32:0]  cx, cy;
  logic signed [33:0]  a_nxt [4];
  logic signed [33:0]  a_r   [4];
  logic signed [25:0]  vwk_r;
  logic signed [25:0]  vwk3_r;
  // stage 3: 0.7071 scale
  logic signed [49:0]  p_r [4];
  // stage 4: rounded mix plus rotation term
  logic signed [49:0]  p_rnd [4];
  logic signed [25:0]  t_r [4];
  // stage 5: gain
  logic signed [42:0]  q_r [4];
  // stage 6: round and saturate
  logic signed [42:0]  q_rnd [4];
  logic signed [22:0]  w_full [4];
  logic signed [15:0]  w_sat [4];
  logic signed [15:0]  w_r [4];
  logic signed [16:0]  gain_s;

  assign en         = !vld_r[NST-1] || out_ready;
  assign item_ready = en;
  assign gain_s     = $signed({1'b0, wheel_gain});

  always_comb begin
    cx = 33'(pxc_r) + 33'(pys_r);
    cy = 33'(pyc_r) - 33'(pxs_r);
    a_nxt[0] = 34'(cx) + 34'(cy);
    a_nxt[1] = 34'(cy) - 34'(cx);
    a_nxt[2] = -34'(cx) - 34'(cy);
    a_nxt[3] = 34'(cx) - 34'(cy);
    for (int k = 0; k < 4; k++) begin
      p_rnd[k] = p_r[k] + 50'sd268435456;
      q_rnd[k] = q_r[k] + 43'sd524288;
      w_full[k] = 23'(q_rnd[k] >>> 20);
      if (w_full[k] > 23'sd32767) begin
        w_sat[k] = 16'sd32767;
      end else if (w_full[k] < -23'sd32768) begin
        w_sat[k] = -16'sd32768;
      end else begin
        w_sat[k] = 16'(w_full[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r[0] <= item.rel_angle;
      for (int i = 1; i < NST; i++) begin
        ang_r[i] <= ang_r[i-1];
      end
      pxc_r  <= 32'(item.vx) * 32'(item.cos_v);
      pys_r  <= 32'(item.vy) * 32'(item.sin_v);
      pxs_r  <= 32'(item.vx) * 32'(item.sin_v);
      pyc_r  <= 32'(item.vy) * 32'(item.cos_v);
      vw1_r  <= item.vw;
      vwk_r  <= 26'(vw1_r) * 26'(VW_K);
      vwk3_r <= vwk_r;
      for (int k = 0; k < 4; k++) begin
        a_r[k] <= a_nxt[k];
        p_r[k] <= 50'(a_r[k]) * 50'(MIX_K);
        t_r[k] <= 26'(p_rnd[k] >>> 29) + vwk3_r;
        q_r[k] <= 43'(t_r[k]) * 43'(gain_s);
        w_r[k] <= w_sat[k];
      end
    end
  end

  assign out_valid          = vld_r[NST-1];
  assign out_relative_angle = ang_r[NST-1];
  assign out_wheel0_speed   = w_r[0];
  assign out_wheel1_speed   = w_r[1];
  assign out_wheel2_speed   = w_r[2];
  assign out_wheel3_speed   = w_r[3];

endmodule

`default_nettype wire
